@@ design/ccs_pkg.sv @@
// ----------------------------------------------------------------------------
// ccs_pkg - shared types and constants for the C comment stripper
// Scanner mode encoding, character codes and the result beat layout.
// ----------------------------------------------------------------------------
package ccs_pkg;

    // Scanner modes, one-hot.
    typedef enum logic [6:0] {
        MODE_NORMAL     = 7'b000_0001,
        MODE_SLASH      = 7'b000_0010,
        MODE_LINE       = 7'b000_0100,
        MODE_BLOCK      = 7'b000_1000,
        MODE_BLOCK_STAR = 7'b001_0000,
        MODE_QUOTE      = 7'b010_0000,
        MODE_QUOTE_ESC  = 7'b100_0000
    } scan_mode_t;

    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    // One result beat.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       run_last;
        logic       text_done;
    } result_t;

    // Everything one input byte produces: up to two result beats.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } emit_t;

endpackage

@@ design/ccs_scan.sv @@
// ----------------------------------------------------------------------------
// ccs_scan - comment scanner state machine
// Holds the scan mode and produces the result beats for each accepted byte.
// ----------------------------------------------------------------------------
module ccs_scan (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           fire,
    input  logic [7:0]     text_byte,
    input  logic           text_last,
    output ccs_pkg::emit_t emit
);

    ccs_pkg::scan_mode_t mode_reg, mode_next;
    logic                quote_single_reg, quote_single_next;

    logic [7:0] e0, e1;
    logic [1:0] cnt;
    logic [7:0] closer;

    always_comb begin
        mode_next         = mode_reg;
        quote_single_next = quote_single_reg;
        e0                = 8'h00;
        e1                = 8'h00;
        cnt               = 2'd0;
        closer            = quote_single_reg ? ccs_pkg::CH_SQUOTE : ccs_pkg::CH_DQUOTE;

        case (mode_reg)
            ccs_pkg::MODE_SLASH: begin
                if (text_byte == ccs_pkg::CH_SLASH) begin
                    mode_next = ccs_pkg::MODE_LINE;
                end else if (text_byte == ccs_pkg::CH_STAR) begin
                    e0        = ccs_pkg::CH_SPACE;
                    cnt       = 2'd1;
                    mode_next = ccs_pkg::MODE_BLOCK;
                end else begin
                    // Release the held slash, then treat the byte as normal text.
                    e0 = ccs_pkg::CH_SLASH;
                    e1 = text_byte;
                    cnt = 2'd2;
                    mode_next = ccs_pkg::MODE_NORMAL;
                    if (text_byte == ccs_pkg::CH_DQUOTE || text_byte == ccs_pkg::CH_SQUOTE) begin
                        quote_single_next = (text_byte == ccs_pkg::CH_SQUOTE);
                        mode_next         = ccs_pkg::MODE_QUOTE;
                    end
                end
            end
            ccs_pkg::MODE_LINE: begin
                if (text_byte == ccs_pkg::CH_NL) begin
                    e0        = ccs_pkg::CH_NL;
                    cnt       = 2'd1;
                    mode_next = ccs_pkg::MODE_NORMAL;
                end
            end
            ccs_pkg::MODE_BLOCK, ccs_pkg::MODE_BLOCK_STAR: begin
                if (mode_reg == ccs_pkg::MODE_BLOCK_STAR && text_byte == ccs_pkg::CH_SLASH) begin
                    mode_next = ccs_pkg::MODE_NORMAL;
                end else if (text_byte == ccs_pkg::CH_STAR) begin
                    mode_next = ccs_pkg::MODE_BLOCK_STAR;
                end else begin
                    if (text_byte == ccs_pkg::CH_NL) begin
                        e0  = ccs_pkg::CH_NL;
                        cnt = 2'd1;
                    end
                    mode_next = ccs_pkg::MODE_BLOCK;
                end
            end
            ccs_pkg::MODE_QUOTE: begin
                e0  = text_byte;
                cnt = 2'd1;
                if (text_byte == ccs_pkg::CH_BSLASH) begin
                    mode_next = ccs_pkg::MODE_QUOTE_ESC;
                end else if (text_byte == closer) begin
                    mode_next = ccs_pkg::MODE_NORMAL;
                end
            end
            ccs_pkg::MODE_QUOTE_ESC: begin
                e0        = text_byte;
                cnt       = 2'd1;
                mode_next = ccs_pkg::MODE_QUOTE;
            end
            default: begin
                mode_next = ccs_pkg::MODE_NORMAL;
                if (text_byte == ccs_pkg::CH_SLASH) begin
                    mode_next = ccs_pkg::MODE_SLASH;
                end else begin
                    e0  = text_byte;
                    cnt = 2'd1;
                    if (text_byte == ccs_pkg::CH_DQUOTE || text_byte == ccs_pkg::CH_SQUOTE) begin
                        quote_single_next = (text_byte == ccs_pkg::CH_SQUOTE);
                        mode_next         = ccs_pkg::MODE_QUOTE;
                    end
                end
            end
        endcase

        // End of text: flush a held slash and return to normal text.
        if (text_last) begin
            if (mode_next == ccs_pkg::MODE_SLASH) begin
                if (cnt == 2'd0) begin
                    e0  = ccs_pkg::CH_SLASH;
                    cnt = 2'd1;
                end else begin
                    e1  = ccs_pkg::CH_SLASH;
                    cnt = 2'd2;
                end
            end
            mode_next         = ccs_pkg::MODE_NORMAL;
            quote_single_next = 1'b0;
        end
    end

    always_comb begin
        if (cnt == 2'd0) begin
            // Nothing to show: the last byte still gives an empty done beat, others give none.
            emit.count  = text_last ? 2'd1 : 2'd0;
            emit.first  = '{out_byte: 8'h00, out_valid: 1'b0, run_last: 1'b1,
                            text_done: 1'b1};
        end else begin
            emit.count  = cnt;
            emit.first  = '{out_byte: e0, out_valid: 1'b1, run_last: (cnt == 2'd1),
                            text_done: (cnt == 2'd1) && text_last};
        end
        emit.second = '{out_byte: e1, out_valid: 1'b1, run_last: 1'b1,
                        text_done: text_last};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= ccs_pkg::MODE_NORMAL;
            quote_single_reg <= 1'b0;
        end else if (fire) begin
            mode_reg         <= mode_next;
            quote_single_reg <= quote_single_next;
        end
    end

endmodule

@@ design/c_comment_stripper.sv @@
// ----------------------------------------------------------------------------
// c_comment_stripper - streaming C comment remover
// Removes line and block comments from C text arriving one byte per beat.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel carries one source byte per beat (s_text_byte) with
//   s_text_last marking the final byte of a text. The m_ channel carries the
//   resulting characters, one per beat: m_out_byte with m_out_valid, plus
//   m_run_last on the last beat caused by an input byte and m_text_done on the
//   final beat of the whole text. An input byte causes zero, one or two beats;
//   the final byte always causes at least one, an empty beat (m_out_valid low)
//   if nothing else is due.
//   The scanner decides the beats combinationally from the incoming byte and
//   its mode register, and writes them into a four-entry result queue that
//   drives the m_ ports directly from its head entry.
//   Throughput is one byte per cycle while s_ready is high. s_ready is high while the queue holds at
//   most two beats, so there is always room for the two beats a byte can make.
//   A byte that makes two beats (a released slash followed by a character)
//   leaves the queue one beat fuller, which is the only cause of a stall in steady flow.
//   When the receiver stalls the queue fills and s_ready drops; no beat is lost.
//   Reset (aresetn low, synchronous) empties the queue and returns the scanner
//   to normal text mode.
// ----------------------------------------------------------------------------
module c_comment_stripper (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_text_byte,
    input  logic       s_text_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_out_valid,
    output logic       m_run_last,
    output logic       m_text_done
);

    ccs_pkg::emit_t   emit;
    ccs_pkg::result_t queue_reg [4];
    ccs_pkg::result_t head;

    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;
    logic [1:0] wr_ptr_p1;
    logic [1:0] push_n;
    logic       s_fire;
    logic       m_fire;

    assign s_ready = (count_reg <= 3'd2);
    assign s_fire  = s_valid && s_ready;
    assign m_valid = (count_reg != 3'd0);
    assign m_fire  = m_valid && m_ready;

    ccs_scan u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (s_fire),
        .text_byte (s_text_byte),
        .text_last (s_text_last),
        .emit      (emit)
    );

    // Beats pushed into the queue this cycle.
    assign push_n    = s_fire ? emit.count : 2'd0;
    assign wr_ptr_p1 = wr_ptr_reg + 2'd1;

    assign wr_ptr_next = wr_ptr_reg + push_n;
    assign rd_ptr_next = rd_ptr_reg + (m_fire ? 2'd1 : 2'd0);
    assign count_next  = count_reg + {1'b0, push_n} - (m_fire ? 3'd1 : 3'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            queue_reg[wr_ptr_reg] <= emit.first;
        end
        if (push_n == 2'd2) begin
            queue_reg[wr_ptr_p1] <= emit.second;
        end
    end

    assign head        = queue_reg[rd_ptr_reg];
    assign m_out_byte  = head.out_byte;
    assign m_out_valid = head.out_valid;
    assign m_run_last  = head.run_last;
    assign m_text_done = head.text_done;

endmodule
